>>> sv/ntc_adc_to_temperature_defines.svh
// assertion macros shared by the ntc converter checker
// no dependencies
`ifndef NTC_ADC_TO_TEMPERATURE_DEFINES_SVH
`define NTC_ADC_TO_TEMPERATURE_DEFINES_SVH

// condition in the same cycle
`define NTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define NTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ntca2t_pkg.sv
// types, constants, microcode rom and resistance curve for the ntc converter
// no dependencies
`timescale 1ns / 1ps

package ntca2t_pkg;

    typedef logic [3:0] t_step;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_PREP1,
        OP_DIV,
        OP_PREP2,
        OP_SAT,
        OP_SEARCH,
        OP_PREP3,
        OP_FIN,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NSTART,
        C_ZERO_SAMPLE,
        C_DIV_BUSY,
        C_DEN_ZERO,
        C_TABLE_GT,
        C_NO_INTERP
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step STEP_WAIT   = 4'd0;
    localparam t_step STEP_PREP1  = 4'd1;
    localparam t_step STEP_DIV1   = 4'd2;
    localparam t_step STEP_PREP2  = 4'd3;
    localparam t_step STEP_DIV2   = 4'd4;
    localparam t_step STEP_SAT    = 4'd5;
    localparam t_step STEP_SEARCH = 4'd6;
    localparam t_step STEP_PREP3  = 4'd7;
    localparam t_step STEP_DIV3   = 4'd8;
    localparam t_step STEP_FIN    = 4'd9;
    localparam t_step STEP_OUT    = 4'd10;

    localparam logic [31:0] SCALE_NUM   = 32'd102300000;
    localparam logic [31:0] DIVIDER_NUM = 32'd1200000000;
    localparam logic [31:0] SCALE_SUB   = 32'd100000;
    localparam logic [8:0]  STEP_CENTI  = 9'd500;
    localparam logic [15:0] RES_SAT     = 16'hFFFF;
    localparam logic [4:0]  DIV_LAST    = 5'd31;
    localparam logic signed [17:0] OUT_MAX = 18'sd16383;
    localparam logic signed [17:0] OUT_MIN = -18'sd16384;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            STEP_WAIT:   w = '{OP_WAIT,   C_NSTART,      STEP_WAIT};
            STEP_PREP1:  w = '{OP_PREP1,  C_ZERO_SAMPLE, STEP_SEARCH};
            STEP_DIV1:   w = '{OP_DIV,    C_DIV_BUSY,    STEP_DIV1};
            STEP_PREP2:  w = '{OP_PREP2,  C_DEN_ZERO,    STEP_SEARCH};
            STEP_DIV2:   w = '{OP_DIV,    C_DIV_BUSY,    STEP_DIV2};
            STEP_SAT:    w = '{OP_SAT,    C_NONE,        STEP_WAIT};
            STEP_SEARCH: w = '{OP_SEARCH, C_TABLE_GT,    STEP_SEARCH};
            STEP_PREP3:  w = '{OP_PREP3,  C_NO_INTERP,   STEP_OUT};
            STEP_DIV3:   w = '{OP_DIV,    C_DIV_BUSY,    STEP_DIV3};
            STEP_FIN:    w = '{OP_FIN,    C_NONE,        STEP_WAIT};
            STEP_OUT:    w = '{OP_OUT,    C_ALWAYS,      STEP_WAIT};
            default:     w = '{OP_WAIT,   C_ALWAYS,      STEP_WAIT};
        endcase
        return w;
    endfunction

    // resistance in 10 ohm units, 0 to 95 degC in 5 degree steps
    function automatic logic [15:0] ntc_curve(input logic [6:0] idx);
        logic [15:0] v;
        case (idx)
            7'd0:    v = 16'd34090;
            7'd1:    v = 16'd26310;
            7'd2:    v = 16'd20440;
            7'd3:    v = 16'd16000;
            7'd4:    v = 16'd12610;
            7'd5:    v = 16'd10000;
            7'd6:    v = 16'd7981;
            7'd7:    v = 16'd6408;
            7'd8:    v = 16'd5174;
            7'd9:    v = 16'd4202;
            7'd10:   v = 16'd3431;
            7'd11:   v = 16'd2816;
            7'd12:   v = 16'd2322;
            7'd13:   v = 16'd1925;
            7'd14:   v = 16'd1603;
            7'd15:   v = 16'd1340;
            7'd16:   v = 16'd1126;
            7'd17:   v = 16'd949;
            7'd18:   v = 16'd804;
            7'd19:   v = 16'd684;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/ntc_adc_to_temperature.sv
// ntc adc sample to temperature converter, microcoded sequencer with shared divider
// depends on ntca2t_pkg
`timescale 1ns / 1ps

// channel   direction  ports                                      handshake
// request   in         i_adc_sample                               start && !busy
// result    out        o_temperature_centi, o_resistance_tens     o_valid, one cycle
// config    in         i_cfg_wdata                                i_cfg_we
//
// one request at a time; from accept to the o_valid strobe the sequencer runs
// up to three 32-step passes of the shared restoring divider and searches the
// resistance table one entry per cycle, sequenced by an 11-word microcode rom.
// synchronous active-low reset returns the step counter to wait and clears the offset.
// the result is shown for exactly one cycle; a new request may start in that cycle.

module ntc_adc_to_temperature #(
    parameter int TABLE_ENTRIES = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         i_adc_sample,
    input  logic               i_cfg_we,
    input  logic signed [13:0] i_cfg_wdata,
    output logic               o_valid,
    output logic signed [14:0] o_temperature_centi,
    output logic [15:0]        o_resistance_tens
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);

    ntca2t_pkg::t_step   r_pc, n_pc;
    logic                r_valid, n_valid;
    logic signed [13:0]  r_offset;
    logic [9:0]          r_sample, n_sample;
    logic [31:0]         r_quo, n_quo;
    logic [26:0]         r_rem, n_rem;
    logic [26:0]         r_den, n_den;
    logic [4:0]          r_cnt, n_cnt;
    logic [15:0]         r_res, n_res;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [15:0]         r_interp, n_interp;
    logic signed [14:0]  r_temp, n_temp;
    logic [15:0]         r_res_out, n_res_out;

    ntca2t_pkg::t_uword  uw;
    logic                take;
    logic [28:0]         trial;
    logic                div_ge;
    logic [31:0]         d_val;
    logic                zero_sample;
    logic                den_zero;
    logic [IDX_W-1:0]    idx_m1;
    logic [15:0]         curve_lo;
    logic [15:0]         curve_hi;
    logic [15:0]         span;
    logic [15:0]         diff;
    logic [24:0]         prod;
    logic [15:0]         idx_step;
    logic                table_gt;
    logic signed [17:0]  t_full;

    assign uw          = ntca2t_pkg::ucode(r_pc);
    assign trial       = {1'b0, r_rem, r_quo[31]} - {2'b00, r_den};
    assign div_ge      = !trial[28];
    assign d_val       = r_quo - ntca2t_pkg::SCALE_SUB;
    assign zero_sample = (r_sample == 10'd0);
    assign den_zero    = (d_val == 32'd0);
    assign idx_m1      = r_idx - 1'b1;
    assign curve_lo    = (int'(r_idx) < TABLE_ENTRIES) ? ntca2t_pkg::ntc_curve(7'(r_idx)) : 16'd0;
    assign curve_hi    = (int'(idx_m1) < TABLE_ENTRIES) ? ntca2t_pkg::ntc_curve(7'(idx_m1)) : 16'd0;
    assign span        = curve_hi - curve_lo;
    assign diff        = r_res - curve_lo;
    assign prod        = diff * ntca2t_pkg::STEP_CENTI;
    assign idx_step    = 16'(r_idx) * 16'(ntca2t_pkg::STEP_CENTI);
    assign table_gt    = (curve_lo > r_res);
    assign t_full      = $signed({2'b00, r_interp}) - $signed({{4{r_offset[13]}}, r_offset});

    assign busy                = (r_pc != ntca2t_pkg::STEP_WAIT);
    assign o_valid             = r_valid;
    assign o_temperature_centi = r_temp;
    assign o_resistance_tens   = r_res_out;

    always_comb begin
        n_valid   = 1'b0;
        n_sample  = r_sample;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_den     = r_den;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_idx     = r_idx;
        n_interp  = r_interp;
        n_temp    = r_temp;
        n_res_out = r_res_out;

        case (uw.op)
            ntca2t_pkg::OP_WAIT: begin
                if (start) begin
                    n_sample = i_adc_sample;
                    n_idx    = '0;
                end
            end
            ntca2t_pkg::OP_PREP1: begin
                if (zero_sample) begin
                    n_res = 16'd0;
                end
                n_quo = ntca2t_pkg::SCALE_NUM;
                n_den = {17'd0, r_sample};
                n_rem = '0;
                n_cnt = ntca2t_pkg::DIV_LAST;
            end
            ntca2t_pkg::OP_DIV: begin
                n_rem = div_ge ? trial[26:0] : {r_rem[25:0], r_quo[31]};
                n_quo = {r_quo[30:0], div_ge};
                n_cnt = r_cnt - 5'd1;
            end
            ntca2t_pkg::OP_PREP2: begin
                if (den_zero) begin
                    n_res = ntca2t_pkg::RES_SAT;
                end else begin
                    n_quo = ntca2t_pkg::DIVIDER_NUM;
                    n_den = d_val[26:0];
                    n_rem = '0;
                    n_cnt = ntca2t_pkg::DIV_LAST;
                end
            end
            ntca2t_pkg::OP_SAT: begin
                n_res = (|r_quo[31:16]) ? ntca2t_pkg::RES_SAT : r_quo[15:0];
            end
            ntca2t_pkg::OP_SEARCH: begin
                if (table_gt) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ntca2t_pkg::OP_PREP3: begin
                n_interp = idx_step;
                n_quo    = {7'd0, prod};
                n_den    = {11'd0, span};
                n_rem    = '0;
                n_cnt    = ntca2t_pkg::DIV_LAST;
            end
            ntca2t_pkg::OP_FIN: begin
                n_interp = r_interp - r_quo[15:0];
            end
            ntca2t_pkg::OP_OUT: begin
                n_valid   = 1'b1;
                n_res_out = r_res;
                if (t_full > ntca2t_pkg::OUT_MAX) begin
                    n_temp = ntca2t_pkg::OUT_MAX[14:0];
                end else if (t_full < ntca2t_pkg::OUT_MIN) begin
                    n_temp = ntca2t_pkg::OUT_MIN[14:0];
                end else begin
                    n_temp = t_full[14:0];
                end
            end
            default: begin
            end
        endcase

        case (uw.cond)
            ntca2t_pkg::C_NONE:        take = 1'b0;
            ntca2t_pkg::C_ALWAYS:      take = 1'b1;
            ntca2t_pkg::C_NSTART:      take = !start;
            ntca2t_pkg::C_ZERO_SAMPLE: take = zero_sample;
            ntca2t_pkg::C_DIV_BUSY:    take = (r_cnt != 5'd0);
            ntca2t_pkg::C_DEN_ZERO:    take = den_zero;
            ntca2t_pkg::C_TABLE_GT:    take = table_gt;
            ntca2t_pkg::C_NO_INTERP:   take = (r_idx == '0) || (span == 16'd0);
            default:                   take = 1'b0;
        endcase

        n_pc = take ? uw.target : r_pc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= ntca2t_pkg::STEP_WAIT;
            r_valid  <= 1'b0;
            r_offset <= '0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
        r_idx     <= n_idx;
        r_interp  <= n_interp;
        r_temp    <= n_temp;
        r_res_out <= n_res_out;
    end

endmodule

>>> sv/ntca2t_checker.sv
// port-level checker for the ntc converter, bound to the top level
// depends on ntc_adc_to_temperature_defines.svh and ntc_adc_to_temperature
`timescale 1ns / 1ps
`include "ntc_adc_to_temperature_defines.svh"

module ntca2t_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [14:0] o_temperature_centi,
    input logic [15:0]        o_resistance_tens
);

    `NTC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after request")
    `NTC_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")
    `NTC_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `NTC_ASSERT_NOW(a_busy_cause, i_clk, i_rst_n, $rose(busy), $past(start), "busy without a request")
    `NTC_ASSERT_NOW(a_result_known, i_clk, i_rst_n, o_valid, !$isunknown(o_temperature_centi) && !$isunknown(o_resistance_tens), "unknown result at strobe")

endmodule

bind ntc_adc_to_temperature ntca2t_checker u_ntca2t_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_valid             (o_valid),
    .o_temperature_centi (o_temperature_centi),
    .o_resistance_tens   (o_resistance_tens)
);

>>> tb/ntc_adc_to_temperature_tb.sv
// self-checking testbench for the ntc adc to temperature converter
// drives samples and offset writes, predicts each reading and checks it field by field
// depends on ntc_adc_to_temperature only
`timescale 1ns / 1ps

module ntc_adc_to_temperature_tb;

    localparam int TABLE_ENTRIES = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 130;
    localparam int OFFSET_MAX    = 8191;
    localparam int OFFSET_MIN    = -8192;
    localparam int TEMP_MAX      = 16383;
    localparam int TEMP_MIN      = -16384;

    typedef struct {
        int temp_centi;
        int res_tens;
    } reading_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [9:0]         i_adc_sample;
    logic               i_cfg_we;
    logic signed [13:0] i_cfg_wdata;
    logic               o_valid;
    logic signed [14:0] o_temperature_centi;
    logic [15:0]        o_resistance_tens;

    int unsigned curve_tens [20] = '{
        34090, 26310, 20440, 16000, 12610, 10000, 7981, 6408, 5174, 4202,
        3431, 2816, 2322, 1925, 1603, 1340, 1126, 949, 804, 684
    };

    reading_t pending_readings [$];
    int       offset_centi;
    int       error_count;
    int       cycle_count;
    int       requests_sent;
    int       readings_checked;
    int       offset_writes;
    int       zero_samples;
    int       saturated_res;
    int       clamped_cold;
    int       past_last_entry;
    int       limited_temps;
    bit       no_idle;

    ntc_adc_to_temperature #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_adc_sample       (i_adc_sample),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_temperature_centi(o_temperature_centi),
        .o_resistance_tens  (o_resistance_tens)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings outstanding",
                     cycle_count, pending_readings.size());
            $display("[ntc_adc_to_temperature] ERROR");
            $finish;
        end
    end

    // divider resistance in 10 ohm units, saturated
    function automatic int unsigned divider_tens(input logic [9:0] sample);
        logic [31:0] quot;
        logic [31:0] den;
        logic [31:0] res;
        if (sample == 10'd0)
            return 0;
        quot = 32'd102300000 / {22'd0, sample};
        den  = quot - 32'd100000;
        if (den == 32'd0)
            return 65535;
        res = 32'd1200000000 / den;
        return (res > 32'd65535) ? 65535 : res;
    endfunction

    function automatic int unsigned curve_entry(input int unsigned k);
        if (k < 20 && k < TABLE_ENTRIES)
            return curve_tens[k];
        return 0;
    endfunction

    function automatic int interp_centi(input int unsigned res);
        int unsigned k;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        k = 0;
        while (k < 64 && curve_entry(k) > res)
            k++;
        if (k == 0) begin
            clamped_cold++;
            return 0;
        end
        if (k >= TABLE_ENTRIES)
            past_last_entry++;
        lo   = curve_entry(k);
        hi   = curve_entry(k - 1);
        span = hi - lo;
        if (span == 0)
            return int'(k * 500);
        return int'(k * 500) - int'(((res - lo) * 500) / span);
    endfunction

    function automatic reading_t predict_reading(input logic [9:0] sample);
        reading_t    r;
        int unsigned res;
        int          t;
        res = divider_tens(sample);
        if (sample == 10'd0)
            zero_samples++;
        if (res == 65535)
            saturated_res++;
        t = interp_centi(res) - offset_centi;
        if (t > TEMP_MAX || t < TEMP_MIN)
            limited_temps++;
        if (t > TEMP_MAX)
            t = TEMP_MAX;
        if (t < TEMP_MIN)
            t = TEMP_MIN;
        r.temp_centi = t;
        r.res_tens   = int'(res);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        reading_t want;
        if (i_rst_n === 1'b1) begin
            if (o_valid !== 1'b0 && o_valid !== 1'b1) begin
                report_mismatch("o_valid unknown", 0, 0);
            end else if (o_valid) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("unexpected result, temperature",
                                    int'(o_temperature_centi), 0);
                end else begin
                    want = pending_readings.pop_front();
                    readings_checked++;
                    if (int'(o_temperature_centi) !== want.temp_centi)
                        report_mismatch("temperature_centi", int'(o_temperature_centi),
                                        want.temp_centi);
                    if (int'(o_resistance_tens) !== want.res_tens)
                        report_mismatch("resistance_tens", int'(o_resistance_tens),
                                        want.res_tens);
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 20);
        return $urandom_range(21, 150);
    endfunction

    function automatic logic [9:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 10'($urandom_range(0, 1023));
        if (roll < 68)
            return 10'($urandom_range(0, 60));
        if (roll < 83)
            return 10'($urandom_range(740, 1023));
        if (roll < 93) begin
            case ($urandom_range(0, 5))
                0: return 10'd0;
                1: return 10'd1;
                2: return 10'd1022;
                3: return 10'd1023;
                4: return 10'($urandom_range(754, 760));
                default: return 10'($urandom_range(862, 868));
            endcase
        end
        return 10'($urandom_range(1000, 1023));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input logic [9:0] sample);
        int gap;
        start        <= 1'b1;
        i_adc_sample <= sample;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_readings.push_back(predict_reading(sample));
        requests_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start        <= 1'b0;
            i_adc_sample <= 10'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // hold requests until every reading is back and the block is idle
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_readings.size() != 0 || busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic set_offset(input int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 14'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 14'($urandom);
        offset_centi = value;
        offset_writes++;
    endtask

    task automatic test_directed_samples();
        logic [9:0] samples [$];
        samples = '{10'd0, 10'd1, 10'd2, 10'd30, 10'd55, 10'd56, 10'd100, 10'd200,
                    10'd340, 10'd512, 10'd600, 10'd700, 10'd756, 10'd757, 10'd800,
                    10'd865, 10'd900, 10'd1022, 10'd1023, 10'h155, 10'h2AA};
        no_idle = 1'b0;
        foreach (samples[k])
            send_request(samples[k]);
    endtask

    task automatic test_offset_limits();
        int offsets [4];
        offsets = '{OFFSET_MAX, OFFSET_MIN, 5000, -5000};
        foreach (offsets[k]) begin
            set_offset(offsets[k]);
            send_request(10'd0);
            send_request(10'd1023);
        end
    endtask

    task automatic test_random_sweep();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_offset(0);
                1: set_offset($urandom_range(0, 10000) - 5000);
                2: set_offset($urandom_range(0, 16383) - 8192);
                3: set_offset(OFFSET_MIN);
                default: set_offset($urandom_range(0, 10000) - 5000);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_request(pick_sample());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_adc_sample     = 10'd0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 14'd0;
        offset_centi     = 0;
        error_count      = 0;
        cycle_count      = 0;
        requests_sent    = 0;
        readings_checked = 0;
        offset_writes    = 0;
        zero_samples     = 0;
        saturated_res    = 0;
        clamped_cold     = 0;
        past_last_entry  = 0;
        limited_temps    = 0;
        no_idle          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_samples();
        test_offset_limits();
        test_random_sweep();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d readings checked, %0d offset writes",
                 requests_sent, readings_checked, offset_writes);
        $display("zero samples %0d, saturated resistance %0d, cold clamp %0d, %s %0d, %s %0d",
                 zero_samples, saturated_res, clamped_cold, "past last entry",
                 past_last_entry, "output limited", limited_temps);
        if (error_count == 0)
            $display("[ntc_adc_to_temperature] OK");
        else
            $display("[ntc_adc_to_temperature] ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ntca2t_pkg.sv
sv/ntc_adc_to_temperature.sv
sv/ntca2t_checker.sv
tb/ntc_adc_to_temperature_tb.sv
